// ===== rtl/bsc_pkg.sv =====
// ============================================================================
// bsc_pkg
// Shared types, constants and multiply helpers for the barometric sensor
// compensation core.
// ============================================================================
package bsc_pkg;

    localparam int DIV_BITS = 64;

    localparam logic [20:0]        PR_FULL    = 21'd1048576;
    localparam logic signed [32:0] TFINE_OFS  = 33'sd128000;
    localparam logic signed [16:0] NUM_SCALE  = 17'sd3125;
    localparam logic [63:0]        Y_BIAS     = 64'h0000_8000_0000_0000;
    localparam logic [31:0]        TEMP_ROUND = 32'd128;

    typedef enum logic [1:0] {
        REG_TCOEF = 2'd0,
        REG_PLOW  = 2'd1,
        REG_PHIGH = 2'd2,
        REG_P9    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] t1;
        logic [15:0] t2;
        logic [15:0] t3;
        logic [15:0] p1;
        logic [15:0] p2;
        logic [15:0] p3;
        logic [15:0] p4;
        logic [15:0] p5;
        logic [15:0] p6;
        logic [15:0] p7;
        logic [15:0] p8;
        logic [15:0] p9;
    } t_coef;

    typedef struct packed {
        logic        vld;
        logic [15:0] temp;
        logic [63:0] num;
        logic [63:0] dv;
    } t_div_in;

    typedef struct packed {
        logic        vld;
        logic [15:0] temp;
        logic        inv;
        logic        neg;
        logic [63:0] q;
    } t_div_out;

    // Low word of a 64-bit operand times a signed 17-bit factor, full product.
    function automatic logic [49:0] mul_lo(input logic [31:0] a,
                                           input logic signed [16:0] b);
        logic signed [49:0] r;
        r = $signed({1'b0, a}) * b;
        return r;
    endfunction

    // Any 32-bit word times a sign-extended 17-bit factor, low 32 bits only.
    function automatic logic [31:0] mul_hi(input logic [31:0] a,
                                           input logic signed [16:0] b);
        logic [31:0] bx;
        bx = {{15{b[16]}}, b};
        return a * bx;
    endfunction

    // Recombines the two partial products into the low 64 bits.
    function automatic logic [63:0] join64(input logic [49:0] lo,
                                           input logic [31:0] hi);
        return {{14{lo[49]}}, lo} + {hi, 32'd0};
    endfunction

endpackage

// ===== rtl/bsc_in_if.sv =====
// ============================================================================
// bsc_in_if
// Input channel: one raw pressure and temperature reading pair per word.
// ============================================================================
interface bsc_in_if;
    logic        valid;
    logic        ready;
    logic [19:0] pressure_raw;
    logic [19:0] temperature_raw;

    modport source (output valid, output pressure_raw, output temperature_raw,
                    input ready);
    modport sink   (input valid, input pressure_raw, input temperature_raw,
                    output ready);
endinterface

// ===== rtl/bsc_out_if.sv =====
// ============================================================================
// bsc_out_if
// Output channel: compensated temperature and pressure per word.
// ============================================================================
interface bsc_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] temperature_centi;
    logic [31:0] pressure_q24_8;
    logic        pressure_invalid;

    modport source (output valid, output temperature_centi, output pressure_q24_8,
                    output pressure_invalid, input ready);
    modport sink   (input valid, input temperature_centi, input pressure_q24_8,
                    input pressure_invalid, output ready);
endinterface

// ===== rtl/bsc_cfg.sv =====
// ============================================================================
// bsc_cfg
// APB register file holding the factory calibration words.
// ============================================================================
module bsc_cfg
    import bsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output t_coef       o_coef
);
    logic [47:0] r_tcoef;
    logic [63:0] r_plow;
    logic [63:0] r_phigh;
    logic [15:0] r_p9;
    t_reg_idx    w_idx;
    logic        w_wr;

    assign w_idx  = t_reg_idx'(paddr[4:3]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcoef <= '0;
            r_plow  <= '0;
            r_phigh <= '0;
            r_p9    <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_TCOEF: r_tcoef <= pwdata[47:0];
                REG_PLOW:  r_plow  <= pwdata;
                REG_PHIGH: r_phigh <= pwdata;
                REG_P9:    r_p9    <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_TCOEF: prdata = {16'd0, r_tcoef};
            REG_PLOW:  prdata = r_plow;
            REG_PHIGH: prdata = r_phigh;
            REG_P9:    prdata = {48'd0, r_p9};
            default:   prdata = '0;
        endcase
    end

    always_comb begin
        o_coef.t1 = r_tcoef[15:0];
        o_coef.t2 = r_tcoef[31:16];
        o_coef.t3 = r_tcoef[47:32];
        o_coef.p1 = r_plow[15:0];
        o_coef.p2 = r_plow[31:16];
        o_coef.p3 = r_plow[47:32];
        o_coef.p4 = r_plow[63:48];
        o_coef.p5 = r_phigh[15:0];
        o_coef.p6 = r_phigh[31:16];
        o_coef.p7 = r_phigh[47:32];
        o_coef.p8 = r_phigh[63:48];
        o_coef.p9 = r_p9;
    end
endmodule

// ===== rtl/bsc_front.sv =====
// ============================================================================
// bsc_front
// Eleven-stage pipeline: temperature compensation, fine temperature, and the
// pressure dividend and divisor.
// ============================================================================
module bsc_front
    import bsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_vld,
    input  logic [19:0] i_pressure_raw,
    input  logic [19:0] i_temperature_raw,
    input  t_coef       i_coef,
    output t_div_in     o_div
);
    // Stage registers.
    logic        r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld;
    logic        r7_vld, r8_vld, r9_vld, r10_vld, r11_vld;
    logic [31:0] r1_taprod, r1_dsq, r2_va, r2_vbprod, r3_tfine;
    logic [20:0] r1_pr, r2_pr, r3_pr, r4_pr, r5_pr, r6_pr, r7_pr;
    logic [15:0] r4_temp, r5_temp, r6_temp, r7_temp, r8_temp, r9_temp;
    logic [15:0] r10_temp, r11_temp;
    logic signed [32:0] r4_v1;
    logic [63:0] r5_vsq;
    logic signed [48:0] r5_v1p5;
    logic [48:0] r5_v1p2, r6_v1p2, r7_v1p2;
    logic [49:0] r6_pp6lo, r6_pp3lo;
    logic [31:0] r6_pp6hi, r6_pp3hi;
    logic [63:0] r6_v2b, r7_v2, r7_x3, r8_x, r8_num0, r9_y;
    logic [49:0] r9_nlo, r10_ylo;
    logic [31:0] r9_nhi, r10_yhi;
    logic [63:0] r10_num, r11_num, r11_dv;

    // Combinational terms.
    logic [31:0]        n1_ta;
    logic signed [17:0] n1_d;
    logic signed [35:0] n1_dsq;
    logic [31:0]        n2_dsh, n2_va, n3_vb;
    logic [31:0]        n4_tf5;
    logic signed [31:0] n4_tc;
    logic [15:0]        n4_temp;
    logic signed [65:0] n5_vsq;
    logic signed [48:0] n5_v1p2;
    logic [63:0]        n11_pr;

    always_comb begin
        n1_ta  = {15'd0, i_temperature_raw[19:3]} - {15'd0, i_coef.t1, 1'b0};
        n1_d   = $signed({2'b0, i_temperature_raw[19:4]}) - $signed({2'b0, i_coef.t1});
        n1_dsq = n1_d * n1_d;
        n2_dsh = $signed(r1_dsq) >>> 12;
        n2_va  = $signed(r1_taprod) >>> 11;
        n3_vb  = $signed(r2_vbprod) >>> 14;
        n4_tf5 = r3_tfine + {r3_tfine[29:0], 2'b0} + TEMP_ROUND;
        n4_tc  = $signed(n4_tf5) >>> 8;
        if (n4_tc > 32'sd32767) begin
            n4_temp = 16'h7fff;
        end else if (n4_tc < -32'sd32768) begin
            n4_temp = 16'h8000;
        end else begin
            n4_temp = n4_tc[15:0];
        end
        n5_vsq  = r4_v1 * r4_v1;
        n5_v1p2 = r4_v1 * $signed(i_coef.p2);
        n11_pr  = join64(r10_ylo, r10_yhi);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0; r2_vld <= 1'b0; r3_vld <= 1'b0; r4_vld <= 1'b0;
            r5_vld <= 1'b0; r6_vld <= 1'b0; r7_vld <= 1'b0; r8_vld <= 1'b0;
            r9_vld <= 1'b0; r10_vld <= 1'b0; r11_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;  r2_vld <= r1_vld; r3_vld <= r2_vld; r4_vld <= r3_vld;
            r5_vld <= r4_vld; r6_vld <= r5_vld; r7_vld <= r6_vld; r8_vld <= r7_vld;
            r9_vld <= r8_vld; r10_vld <= r9_vld; r11_vld <= r10_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // Temperature, 32-bit wrapping.
            r1_taprod <= mul_hi(n1_ta, {i_coef.t2[15], i_coef.t2});
            r1_dsq    <= n1_dsq[31:0];
            r1_pr     <= PR_FULL - {1'b0, i_pressure_raw};
            r2_va     <= n2_va;
            r2_vbprod <= mul_hi(n2_dsh, {i_coef.t3[15], i_coef.t3});
            r2_pr     <= r1_pr;
            r3_tfine  <= r2_va + n3_vb;
            r3_pr     <= r2_pr;
            r4_temp   <= n4_temp;
            r4_v1     <= $signed({r3_tfine[31], r3_tfine}) - TFINE_OFS;
            r4_pr     <= r3_pr;
            // Pressure, 64-bit wrapping.
            r5_temp   <= r4_temp;
            r5_vsq    <= n5_vsq[63:0];
            r5_v1p5   <= r4_v1 * $signed(i_coef.p5);
            r5_v1p2   <= n5_v1p2;
            r5_pr     <= r4_pr;
            r6_temp   <= r5_temp;
            r6_pp6lo  <= mul_lo(r5_vsq[31:0],  {i_coef.p6[15], i_coef.p6});
            r6_pp6hi  <= mul_hi(r5_vsq[63:32], {i_coef.p6[15], i_coef.p6});
            r6_pp3lo  <= mul_lo(r5_vsq[31:0],  {i_coef.p3[15], i_coef.p3});
            r6_pp3hi  <= mul_hi(r5_vsq[63:32], {i_coef.p3[15], i_coef.p3});
            r6_v2b    <= {r5_v1p5[46:0], 17'd0}
                       + {{13{i_coef.p4[15]}}, i_coef.p4, 35'd0};
            r6_v1p2   <= r5_v1p2;
            r6_pr     <= r5_pr;
            r7_temp   <= r6_temp;
            r7_v2     <= join64(r6_pp6lo, r6_pp6hi) + r6_v2b;
            r7_x3     <= join64(r6_pp3lo, r6_pp3hi);
            r7_v1p2   <= r6_v1p2;
            r7_pr     <= r6_pr;
            r8_temp   <= r7_temp;
            r8_x      <= 64'($signed(r7_x3) >>> 8) + {{3{r7_v1p2[48]}}, r7_v1p2, 12'd0};
            r8_num0   <= {12'd0, r7_pr, 31'd0} - r7_v2;
            r9_temp   <= r8_temp;
            r9_y      <= r8_x + Y_BIAS;
            r9_nlo    <= mul_lo(r8_num0[31:0],  NUM_SCALE);
            r9_nhi    <= mul_hi(r8_num0[63:32], NUM_SCALE);
            r10_temp  <= r9_temp;
            r10_ylo   <= mul_lo(r9_y[31:0],  {1'b0, i_coef.p1});
            r10_yhi   <= mul_hi(r9_y[63:32], {1'b0, i_coef.p1});
            r10_num   <= join64(r9_nlo, r9_nhi);
            r11_temp  <= r10_temp;
            r11_dv    <= $signed(n11_pr) >>> 33;
            r11_num   <= r10_num;
        end
    end

    always_comb begin
        o_div.vld  = r11_vld;
        o_div.temp = r11_temp;
        o_div.num  = r11_num;
        o_div.dv   = r11_dv;
    end
endmodule

// ===== rtl/bsc_div.sv =====
// ============================================================================
// bsc_div
// Pipelined signed 64-bit divider, one quotient bit per stage, truncating
// toward zero.
// ============================================================================
module bsc_div
    import bsc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_en,
    input  t_div_in  i_div,
    output t_div_out o_div
);
    logic [63:0] r_rem  [DIV_BITS+1];
    logic [63:0] r_q    [DIV_BITS+1];
    logic [63:0] r_mb   [DIV_BITS+1];
    logic        r_vld  [DIV_BITS+1];
    logic        r_neg  [DIV_BITS+1];
    logic        r_inv  [DIV_BITS+1];
    logic [15:0] r_temp [DIV_BITS+1];

    // Sign handling: operate on magnitudes, fix the sign afterward.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_div.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= '0;
            r_q[0]    <= i_div.num[63] ? (64'd0 - i_div.num) : i_div.num;
            r_mb[0]   <= i_div.dv[63]  ? (64'd0 - i_div.dv)  : i_div.dv;
            r_neg[0]  <= i_div.num[63] ^ i_div.dv[63];
            r_inv[0]  <= (i_div.dv == 64'd0);
            r_temp[0] <= i_div.temp;
        end
    end

    for (genvar g = 0; g < DIV_BITS; g++) begin : g_stage
        logic [64:0] w_sh;
        logic [64:0] w_df;
        logic        w_ge;

        assign w_sh = {r_rem[g], r_q[g][63]};
        assign w_df = w_sh - {1'b0, r_mb[g]};
        assign w_ge = !w_df[64];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[g+1] <= r_vld[g];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g+1]  <= w_ge ? w_df[63:0] : w_sh[63:0];
                r_q[g+1]    <= {r_q[g][62:0], w_ge};
                r_mb[g+1]   <= r_mb[g];
                r_neg[g+1]  <= r_neg[g];
                r_inv[g+1]  <= r_inv[g];
                r_temp[g+1] <= r_temp[g];
            end
        end
    end

    always_comb begin
        o_div.vld  = r_vld[DIV_BITS];
        o_div.temp = r_temp[DIV_BITS];
        o_div.inv  = r_inv[DIV_BITS];
        o_div.neg  = r_neg[DIV_BITS];
        o_div.q    = r_q[DIV_BITS];
    end
endmodule

// ===== rtl/bsc_back.sv =====
// ============================================================================
// bsc_back
// Seven-stage pipeline after the divider: second-order pressure terms and
// the output register.
// ============================================================================
module bsc_back
    import bsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_div_out    i_div,
    input  t_coef       i_coef,
    output logic        o_vld,
    output logic [15:0] o_temp,
    output logic [31:0] o_pres,
    output logic        o_inv
);
    logic        r1_vld, r2_vld, r3_vld, r4_vld, r5_vld, r6_vld, r7_vld;
    logic [15:0] r1_temp, r2_temp, r3_temp, r4_temp, r5_temp, r6_temp, r7_temp;
    logic        r1_inv, r2_inv, r3_inv, r4_inv, r5_inv, r6_inv, r7_inv;
    logic [63:0] r1_p, r2_p, r3_p, r4_p, r5_p, r2_ph, r3_ph;
    logic [49:0] r2_alo, r2_blo;
    logic [31:0] r2_ahi, r2_bhi;
    logic [63:0] r3_m1, r3_v2, r4_v2, r5_v2, r4_c0, r5_v1, r6_s;
    logic [31:0] r4_c1, r4_c2;
    logic [31:0] r7_pres;

    logic [63:0] n2_ph, n5_sum, n7_p;

    always_comb begin
        n2_ph  = $signed(r1_p) >>> 13;
        n5_sum = r4_c0 + {r4_c1 + r4_c2, 32'd0};
        n7_p   = 64'($signed(r6_s) >>> 8) + {{44{i_coef.p7[15]}}, i_coef.p7, 4'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0; r2_vld <= 1'b0; r3_vld <= 1'b0; r4_vld <= 1'b0;
            r5_vld <= 1'b0; r6_vld <= 1'b0; r7_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_div.vld; r2_vld <= r1_vld; r3_vld <= r2_vld;
            r4_vld <= r3_vld; r5_vld <= r4_vld; r6_vld <= r5_vld; r7_vld <= r6_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_temp <= i_div.temp; r1_inv <= i_div.inv;
            r1_p    <= i_div.neg ? (64'd0 - i_div.q) : i_div.q;
            r2_temp <= r1_temp; r2_inv <= r1_inv;
            r2_p    <= r1_p;
            r2_ph   <= n2_ph;
            r2_alo  <= mul_lo(n2_ph[31:0],  {i_coef.p9[15], i_coef.p9});
            r2_ahi  <= mul_hi(n2_ph[63:32], {i_coef.p9[15], i_coef.p9});
            r2_blo  <= mul_lo(r1_p[31:0],   {i_coef.p8[15], i_coef.p8});
            r2_bhi  <= mul_hi(r1_p[63:32],  {i_coef.p8[15], i_coef.p8});
            r3_temp <= r2_temp; r3_inv <= r2_inv;
            r3_p    <= r2_p;
            r3_ph   <= r2_ph;
            r3_m1   <= join64(r2_alo, r2_ahi);
            r3_v2   <= $signed(join64(r2_blo, r2_bhi)) >>> 19;
            // Low 64 bits of the 64 by 64 product, from three 32 by 32 pieces.
            r4_temp <= r3_temp; r4_inv <= r3_inv;
            r4_p    <= r3_p;
            r4_v2   <= r3_v2;
            r4_c0   <= 64'(r3_ph[31:0]) * 64'(r3_m1[31:0]);
            r4_c1   <= r3_ph[31:0] * r3_m1[63:32];
            r4_c2   <= r3_ph[63:32] * r3_m1[31:0];
            r5_temp <= r4_temp; r5_inv <= r4_inv;
            r5_p    <= r4_p;
            r5_v2   <= r4_v2;
            r5_v1   <= $signed(n5_sum) >>> 25;
            r6_temp <= r5_temp; r6_inv <= r5_inv;
            r6_s    <= r5_p + r5_v1 + r5_v2;
            r7_temp <= r6_temp; r7_inv <= r6_inv;
            r7_pres <= r6_inv ? 32'd0 : n7_p[31:0];
        end
    end

    assign o_vld  = r7_vld;
    assign o_temp = r7_temp;
    assign o_pres = r7_pres;
    assign o_inv  = r7_inv;
endmodule

// ===== rtl/barometric_sensor_compensation_core.sv =====
// ============================================================================
// barometric_sensor_compensation_core
// Integer temperature and pressure compensation of raw converter readings.
// ============================================================================
// Channel   Dir   Handshake        Word
// i_in      in    valid/ready      pressure_raw, temperature_raw
// o_out     out   valid/ready      temperature_centi, pressure_q24_8, pressure_invalid
// APB       in    psel/penable     calibration registers at 8 * index
//
// One word is accepted per cycle while the output word is not held; each
// word goes from acceptance through 11 front stages, 65 divider stages (an
// input stage, then one quotient bit each), and 7 back stages to the output
// register. Reset clears all valid bits and the calibration registers. When
// the output word is held, the whole pipeline holds in place and input ready drops.
// ============================================================================
module barometric_sensor_compensation_core
    import bsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsc_in_if.sink      i_in,
    bsc_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    t_coef    w_coef;
    t_div_in  w_div_in;
    t_div_out w_div_out;
    logic     w_en;

    assign w_en       = !o_out.valid || o_out.ready;
    assign i_in.ready = w_en;

    bsc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_coef  (w_coef)
    );

    bsc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_en              (w_en),
        .i_vld             (i_in.valid),
        .i_pressure_raw    (i_in.pressure_raw),
        .i_temperature_raw (i_in.temperature_raw),
        .i_coef            (w_coef),
        .o_div             (w_div_in)
    );

    bsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_div   (w_div_in),
        .o_div   (w_div_out)
    );

    bsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_div   (w_div_out),
        .i_coef  (w_coef),
        .o_vld   (o_out.valid),
        .o_temp  (o_out.temperature_centi),
        .o_pres  (o_out.pressure_q24_8),
        .o_inv   (o_out.pressure_invalid)
    );

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("output valid after reset");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.pressure_invalid |-> o_out.pressure_q24_8 == 32'd0)
        else $error("invalid pressure word is not zero");

    a_div_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_div_out.vld) && $stable(w_div_out.q))
        else $error("divider moved during a stall");
endmodule

// ===== dv/barometric_sensor_compensation_core_test.sv =====
// ============================================================================
// barometric_sensor_compensation_core_test
// Self-checking regression for the barometric sensor compensation core.
// Reading pairs are streamed through the input channel under varying
// back-pressure. A bit-exact predictor computes the compensated temperature
// and pressure for every accepted word, and the monitor compares each output
// word in order. Calibration registers are rewritten between phases while
// the pipeline is empty.
// ============================================================================
module barometric_sensor_compensation_core_test
    import bsc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct packed {
        logic [19:0] pressure_raw;
        logic [19:0] temperature_raw;
    } t_reading;

    typedef struct packed {
        logic [15:0] temperature_centi;
        logic [31:0] pressure_q24_8;
        logic        pressure_invalid;
    } t_compensated;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    bsc_in_if  in_if ();
    bsc_out_if out_if ();

    barometric_sensor_compensation_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if.sink),
        .o_out   (out_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Mirror of the calibration registers.
    logic [47:0] cal_temp;
    logic [63:0] cal_press_low;
    logic [63:0] cal_press_high;
    logic [15:0] cal_nine;

    t_reading     pending_readings[$];
    t_compensated expected_words[$];
    int           send_idle_pct;
    int           recv_idle_pct;
    int           mismatches = 0;
    int           quiet_cycles = 0;

    function automatic logic signed [63:0] sext16(input logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic signed [63:0] trunc_div(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] q;
        ma = a[63] ? -a : a;
        mb = b[63] ? -b : b;
        q  = ma / mb;
        return (a[63] != b[63]) ? -q : q;
    endfunction

    function automatic t_compensated compensate(input t_reading r);
        logic signed [31:0] t1, t2, t3, a, va, d, vb, tfine, tc, ts3, ts4;
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] v1, v2, p, ph;
        t_compensated res;
        t1  = {16'd0, cal_temp[15:0]};
        t2  = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3  = {{16{cal_temp[47]}}, cal_temp[47:32]};
        ts3 = {15'd0, r.temperature_raw[19:3]};
        ts4 = {16'd0, r.temperature_raw[19:4]};
        a     = (ts3 - (t1 <<< 1)) * t2;
        va    = a >>> 11;
        d     = ts4 - t1;
        vb    = (((d * d) >>> 12) * t3) >>> 14;
        tfine = va + vb;
        tc    = (tfine * 5 + 128) >>> 8;
        if (tc > 32767) begin
            res.temperature_centi = 16'h7fff;
        end else if (tc < -32768) begin
            res.temperature_centi = 16'h8000;
        end else begin
            res.temperature_centi = tc[15:0];
        end

        p1 = {48'd0, cal_press_low[15:0]};
        p2 = sext16(cal_press_low[31:16]);
        p3 = sext16(cal_press_low[47:32]);
        p4 = sext16(cal_press_low[63:48]);
        p5 = sext16(cal_press_high[15:0]);
        p6 = sext16(cal_press_high[31:16]);
        p7 = sext16(cal_press_high[47:32]);
        p8 = sext16(cal_press_high[63:48]);
        p9 = sext16(cal_nine);

        v1 = {{32{tfine[31]}}, tfine} - 64'sd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
        if (v1 == 0) begin
            res.pressure_q24_8   = '0;
            res.pressure_invalid = 1'b1;
        end else begin
            p  = 64'sd1048576 - {44'd0, r.pressure_raw};
            p  = trunc_div(((p <<< 31) - v2) * 64'sd3125, v1);
            ph = p >>> 13;
            v1 = (p9 * ph * ph) >>> 25;
            v2 = (p8 * p) >>> 19;
            p  = ((p + v1 + v2) >>> 8) + (p7 <<< 4);
            res.pressure_q24_8   = p[31:0];
            res.pressure_invalid = 1'b0;
        end
        return res;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Driver: a word stays on the bus until it is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid           <= 1'b0;
            in_if.pressure_raw    <= '0;
            in_if.temperature_raw <= '0;
        end else if (!in_if.valid || in_if.ready) begin
            if (in_if.valid) begin
                expected_words.push_back(compensate({in_if.pressure_raw,
                                                     in_if.temperature_raw}));
            end
            if (pending_readings.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                t_reading r;
                r = pending_readings.pop_front();
                in_if.valid           <= 1'b1;
                in_if.pressure_raw    <= r.pressure_raw;
                in_if.temperature_raw <= r.temperature_raw;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Monitor and receiver back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output word t=%h p=%h inv=%b",
                                 out_if.temperature_centi, out_if.pressure_q24_8,
                                 out_if.pressure_invalid);
                end else begin
                    t_compensated e;
                    e = expected_words.pop_front();
                    if (e.temperature_centi !== out_if.temperature_centi
                        || e.pressure_q24_8 !== out_if.pressure_q24_8
                        || e.pressure_invalid !== out_if.pressure_invalid) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected t=%h p=%h inv=%b, got t=%h p=%h inv=%b",
                                     e.temperature_centi, e.pressure_q24_8,
                                     e.pressure_invalid, out_if.temperature_centi,
                                     out_if.pressure_q24_8, out_if.pressure_invalid);
                    end
                end
            end
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("barometric_sensor_compensation_core regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_register(input t_reg_idx idx, input logic [63:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 5'(idx) << 3;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_TCOEF: cal_temp       = value[47:0];
            REG_PLOW:  cal_press_low  = value;
            REG_PHIGH: cal_press_high = value;
            REG_P9:    cal_nine       = value[15:0];
            default: ;
        endcase
    endtask

    task automatic load_calibration(input logic [47:0] tc, input logic [63:0] pl,
                                    input logic [63:0] ph, input logic [15:0] p9);
        write_register(REG_TCOEF, {16'd0, tc});
        write_register(REG_PLOW, pl);
        write_register(REG_PHIGH, ph);
        write_register(REG_P9, {48'd0, p9});
    endtask

    task automatic wait_drained();
        while (pending_readings.size() > 0 || in_if.valid || expected_words.size() > 0)
            @(posedge i_clk);
    endtask

    task automatic queue_reading(input logic [19:0] pr, input logic [19:0] tr);
        t_reading r;
        r.pressure_raw    = pr;
        r.temperature_raw = tr;
        pending_readings.push_back(r);
    endtask

    localparam logic [47:0] TYP_TEMP = {16'hfc18, 16'd26435, 16'd27504};
    localparam logic [63:0] TYP_PLOW = {16'd2855, 16'd3024, 16'hd643, 16'd36477};
    localparam logic [63:0] TYP_PHIGH = {16'hc6f8, 16'd15500, 16'hfff9, 16'd140};
    localparam logic [15:0] TYP_NINE = 16'd6000;

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cal_temp = '0;
        cal_press_low = '0;
        cal_press_high = '0;
        cal_nine = '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset calibration: the pressure divisor is zero for every word.
        queue_reading(20'd0, 20'd0);
        queue_reading(20'hfffff, 20'hfffff);
        queue_reading(20'd519888, 20'd415148);
        wait_drained();

        load_calibration(TYP_TEMP, TYP_PLOW, TYP_PHIGH, TYP_NINE);
        queue_reading(20'd519888, 20'd415148);
        queue_reading(20'd0, 20'd0);
        queue_reading(20'hfffff, 20'hfffff);
        queue_reading(20'd0, 20'hfffff);
        queue_reading(20'hfffff, 20'd0);
        queue_reading(20'h80000, 20'h7ffff);
        queue_reading(20'h55555, 20'haaaaa);
        queue_reading(20'haaaaa, 20'h55555);
        wait_drained();

        // Extreme coefficients drive temperature saturation and wraparound.
        load_calibration('1, '1, '1, 16'hffff);
        queue_reading(20'd0, 20'd0);
        queue_reading(20'hfffff, 20'hfffff);
        queue_reading(20'd519888, 20'd415148);
        wait_drained();
        load_calibration({16'h7fff, 16'h7fff, 16'd0}, {16'h7fff, 16'h7fff, 16'h7fff, 16'hffff},
                         {16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff}, 16'h7fff);
        queue_reading(20'd0, 20'hfffff);
        queue_reading(20'hfffff, 20'd0);
        queue_reading(20'd0, 20'd0);
        wait_drained();
        load_calibration({16'h8000, 16'h8000, 16'hffff}, {16'h8000, 16'h8000, 16'h8000, 16'd1},
                         {16'h8000, 16'h8000, 16'h8000, 16'h8000}, 16'h8000);
        queue_reading(20'd0, 20'hfffff);
        queue_reading(20'hfffff, 20'd0);
        queue_reading(20'h12345, 20'h6789a);
        wait_drained();

        for (int phase = 0; phase < 6; phase++) begin
            case (phase / 2)
                0: begin send_idle_pct = 18; recv_idle_pct = 83; end
                1: begin send_idle_pct = 83; recv_idle_pct = 18; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            if (phase % 3 == 0) begin
                load_calibration(TYP_TEMP, TYP_PLOW, TYP_PHIGH, TYP_NINE);
            end else begin
                load_calibration(48'({$urandom, $urandom}), {$urandom, $urandom},
                                 {$urandom, $urandom}, 16'($urandom));
            end
            for (int n = 0; n < 65; n++) begin
                if (phase % 3 == 0 && n % 2 == 0)
                    // Near a realistic operating point.
                    queue_reading(20'($urandom_range(600000, 250000)),
                                  20'($urandom_range(560000, 380000)));
                else
                    queue_reading(20'($urandom), 20'($urandom));
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_words.size() == 0) begin
            $display("barometric_sensor_compensation_core regression: pass");
        end else begin
            $display("barometric_sensor_compensation_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/bsc_pkg.sv
rtl/bsc_in_if.sv
rtl/bsc_out_if.sv
rtl/bsc_cfg.sv
rtl/bsc_front.sv
rtl/bsc_div.sv
rtl/bsc_back.sv
rtl/barometric_sensor_compensation_core.sv
dv/barometric_sensor_compensation_core_test.sv
